FILE: rtl/hsi_pkg.sv
// Shared types, constants and tables for the HSI saturation/intensity adjust block.
package hsi_pkg;

   localparam int TRIG_ITERATIONS = 16;
   localparam int ATAN_ENTRIES    = 24;
   localparam int TRIG_STEPS      = (TRIG_ITERATIONS < ATAN_ENTRIES) ?
                                    TRIG_ITERATIONS : ATAN_ENTRIES;
   localparam int SAT_DIV_STEPS   = 16;
   localparam int FRONT_STAGES    = (TRIG_STEPS > SAT_DIV_STEPS) ? TRIG_STEPS : SAT_DIV_STEPS;
   localparam int RATIO_DIV_STEPS = 18;
   localparam int PIPE_LATENCY    = FRONT_STAGES + TRIG_STEPS + RATIO_DIV_STEPS + 7;

   localparam logic [15:0]        GAIN_RESET   = 16'd4506;
   localparam logic signed [8:0]  OFFSET_RESET = 9'sd50;

   localparam logic CSR_GAIN   = 1'b0;
   localparam logic CSR_OFFSET = 1'b1;

   localparam logic signed [26:0] HUE_HALF_Q16 = 27'sd11796480;
   localparam logic signed [26:0] HUE_FULL_Q16 = 27'sd23592960;
   localparam logic [15:0]        DEG120_Q7    = 16'd15360;
   localparam logic [15:0]        DEG240_Q7    = 16'd30720;
   localparam logic signed [23:0] DEG60_Q16    = 24'sd3932160;
   localparam logic signed [25:0] SQRT3_Q14    = 26'sd28378;
   localparam logic [47:0]        HALF_SQRT3_Q16 = 48'd56756;
   localparam logic [35:0]        THIRD_RECIP  = 36'd174763;
   localparam logic [15:0]        SAT_ONE      = 16'd32768;
   localparam logic signed [32:0] ROT_X_INIT   = 33'sd1073741824;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } pixel_in_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } pixel_out_type;

   typedef struct packed {
      logic [15:0] hue;
      logic [15:0] sat;
      logic [15:0] inten;
   } hsi_type;

   typedef struct packed {
      sector_type         sector;
      logic [19:0]        sat_g;
      logic signed [17:0] inten;
   } side_type;

   typedef struct packed {
      side_type           side;
      logic signed [19:0] ratio;
   } synth_in_type;

   // atan(2^-i) in degrees, Q.16
   function automatic logic [21:0] atan_q16(input int idx);
      logic [21:0] v;
      case (idx)
         0:  v = 22'd2949120;
         1:  v = 22'd1740967;
         2:  v = 22'd919879;
         3:  v = 22'd466945;
         4:  v = 22'd234379;
         5:  v = 22'd117306;
         6:  v = 22'd58666;
         7:  v = 22'd29335;
         8:  v = 22'd14668;
         9:  v = 22'd7334;
         10: v = 22'd3667;
         11: v = 22'd1833;
         12: v = 22'd917;
         13: v = 22'd458;
         14: v = 22'd229;
         15: v = 22'd115;
         16: v = 22'd57;
         17: v = 22'd29;
         18: v = 22'd14;
         19: v = 22'd7;
         20: v = 22'd4;
         21: v = 22'd2;
         22: v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/hsi_saturation_intensity_adjust_unit.sv
// Top level: register port and the analyze / ratio / synth pipeline.
//
// One RGB pixel in per clock, one adjusted RGB pixel out per pixel. busy is
// low except during reset, so a pixel may be started in every cycle; each
// result shows on rsp_pixel with rsp_strobe for a single cycle, after the
// 16 hue CORDIC stages, 16 rotation CORDIC stages, 18 ratio divider stages
// and the setup, multiply and clamp stages.
// The receiver must take every result as it comes. Registers: address 0 is
// the saturation gain (Q4.12), address 4 the signed intensity offset; write
// them only while no pixel is in flight.
module hsi_saturation_intensity_adjust_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  hsi_pkg::pixel_in_type  req_pixel,
   output logic                   rsp_strobe,
   output hsi_pkg::pixel_out_type rsp_pixel,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import hsi_pkg::*;

   logic [15:0]       gain_ff, gain_in;
   logic signed [8:0] offset_ff, offset_in;
   logic              wr_c, accept_c;

   logic              a_valid;
   hsi_type           a_hsi;
   logic              r_valid;
   synth_in_type      r_data;

   assign busy = reset;
   assign pready = 1'b1;
   assign accept_c = start && !busy;
   assign wr_c = psel && penable && pwrite;

   always_comb begin
      gain_in = gain_ff;
      offset_in = offset_ff;
      if (wr_c) begin
         case (paddr[2])
            CSR_GAIN:   gain_in = pwdata[15:0];
            CSR_OFFSET: offset_in = $signed(pwdata[8:0]);
            default:    gain_in = gain_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
         offset_ff <= OFFSET_RESET;
      end else begin
         gain_ff <= gain_in;
         offset_ff <= offset_in;
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_GAIN:   prdata = {16'b0, gain_ff};
         CSR_OFFSET: prdata = {{23{offset_ff[8]}}, offset_ff};
         default:    prdata = '0;
      endcase
   end

   hsi_analyze u_analyze (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept_c),
      .in_pixel  (req_pixel),
      .out_valid (a_valid),
      .out_hsi   (a_hsi)
   );

   hsi_ratio u_ratio (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid),
      .in_hsi    (a_hsi),
      .gain      (gain_ff),
      .offset    (offset_ff),
      .out_valid (r_valid),
      .out_data  (r_data)
   );

   hsi_synth u_synth (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (r_valid),
      .in_data    (r_data),
      .out_strobe (rsp_strobe),
      .out_pixel  (rsp_pixel)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept_c, PIPE_LATENCY + 1))
      else $error("result strobe without a matching start");

   a_gain_write: assert property (@(posedge clock) disable iff (reset)
      wr_c && (paddr[2] == CSR_GAIN) |=> gain_ff == $past(pwdata[15:0]))
      else $error("gain register write lost");

endmodule

FILE: rtl/hsi_analyze.sv
// RGB to HSI: vectoring CORDIC for hue alongside a restoring divider for saturation.
module hsi_analyze (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  hsi_pkg::pixel_in_type in_pixel,
   output logic                 out_valid,
   output hsi_pkg::hsi_type     out_hsi
);
   import hsi_pkg::*;

   localparam int F = FRONT_STAGES;

   logic [9:0]         r_c, g_c, b_c, sum_c, mn_c, n3_c;
   logic signed [10:0] dx_c, dy_c;
   logic signed [25:0] x_c, y_c, dy_ext;
   logic signed [25:0] x0_c, y0_c;
   logic signed [26:0] z0_c;
   logic [35:0]        iprod_c;

   logic [F:0]         vld_ff;
   logic signed [25:0] x_ff [0:F];
   logic signed [25:0] y_ff [0:F];
   logic signed [26:0] z_ff [0:F];
   logic [9:0]         rem_ff [0:F];
   logic [15:0]        q_ff [0:F];
   logic [9:0]         den_ff [0:F];
   logic [15:0]        inten_ff [0:F];
   logic [F:0]         gray_ff, black_ff;

   logic signed [25:0] x_in [0:F-1];
   logic signed [25:0] y_in [0:F-1];
   logic signed [26:0] z_in [0:F-1];
   logic [9:0]         rem_in [0:F-1];
   logic [15:0]        q_in [0:F-1];

   logic signed [26:0] zw_c;
   hsi_type            out_in, out_ff;
   logic               out_vld_ff;

   always_comb begin
      r_c = {2'b0, in_pixel.red_in};
      g_c = {2'b0, in_pixel.green_in};
      b_c = {2'b0, in_pixel.blue_in};
      sum_c = r_c + g_c + b_c;
      mn_c = (r_c < g_c) ? r_c : g_c;
      if (b_c < mn_c) begin
         mn_c = b_c;
      end
      n3_c = 10'(mn_c * 10'd3);
      dx_c = $signed({r_c, 1'b0}) - $signed({1'b0, g_c}) - $signed({1'b0, b_c});
      dy_c = $signed({1'b0, g_c}) - $signed({1'b0, b_c});
      x_c = 26'($signed({dx_c, 14'b0}));
      dy_ext = 26'(dy_c);
      y_c = dy_ext * SQRT3_Q14;
      // left half-plane: flip the vector and start the angle at 180 degrees
      if (x_c < 0) begin
         x0_c = -x_c;
         y0_c = -y_c;
         z0_c = HUE_HALF_Q16;
      end else begin
         x0_c = x_c;
         y0_c = y_c;
         z0_c = '0;
      end
      iprod_c = {18'b0, sum_c, 8'b0} * THIRD_RECIP;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[F-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]     <= x0_c;
      y_ff[0]     <= y0_c;
      z_ff[0]     <= z0_c;
      rem_ff[0]   <= n3_c;
      q_ff[0]     <= '0;
      den_ff[0]   <= sum_c;
      inten_ff[0] <= iprod_c[34:19];
      gray_ff[0]  <= (r_c == g_c) && (g_c == b_c);
      black_ff[0] <= (sum_c == '0);
   end

   for (genvar i = 0; i < F; i++) begin : g_stage
      if (i < TRIG_STEPS) begin : g_rot
         logic signed [26:0] ang;
         logic               up;
         assign ang = $signed({5'b0, atan_q16(i)});
         assign up = (y_ff[i] > 0);
         assign x_in[i] = up ? x_ff[i] + (y_ff[i] >>> i) : x_ff[i] - (y_ff[i] >>> i);
         assign y_in[i] = up ? y_ff[i] - (x_ff[i] >>> i) : y_ff[i] + (x_ff[i] >>> i);
         assign z_in[i] = up ? z_ff[i] + ang : z_ff[i] - ang;
      end else begin : g_rot_pass
         assign x_in[i] = x_ff[i];
         assign y_in[i] = y_ff[i];
         assign z_in[i] = z_ff[i];
      end

      if (i < SAT_DIV_STEPS) begin : g_div
         logic [10:0] trial, diff;
         logic        ge;
         // first step resolves the integer bit, so no shift
         if (i == 0) begin : g_first
            assign trial = {1'b0, rem_ff[i]};
         end else begin : g_next
            assign trial = {rem_ff[i], 1'b0};
         end
         assign ge = (trial >= {1'b0, den_ff[i]});
         assign diff = trial - {1'b0, den_ff[i]};
         assign rem_in[i] = ge ? diff[9:0] : trial[9:0];
         assign q_in[i] = {q_ff[i][14:0], ge};
      end else begin : g_div_pass
         assign rem_in[i] = rem_ff[i];
         assign q_in[i] = q_ff[i];
      end

      always_ff @(posedge clock) begin
         x_ff[i+1]     <= x_in[i];
         y_ff[i+1]     <= y_in[i];
         z_ff[i+1]     <= z_in[i];
         rem_ff[i+1]   <= rem_in[i];
         q_ff[i+1]     <= q_in[i];
         den_ff[i+1]   <= den_ff[i];
         inten_ff[i+1] <= inten_ff[i];
         gray_ff[i+1]  <= gray_ff[i];
         black_ff[i+1] <= black_ff[i];
      end
   end

   always_comb begin
      if (z_ff[F] < 0) begin
         zw_c = z_ff[F] + HUE_FULL_Q16;
      end else if (z_ff[F] >= HUE_FULL_Q16) begin
         zw_c = z_ff[F] - HUE_FULL_Q16;
      end else begin
         zw_c = z_ff[F];
      end
      out_in.hue = gray_ff[F] ? '0 : zw_c[24:9];
      out_in.sat = black_ff[F] ? '0 : SAT_ONE - q_ff[F];
      out_in.inten = inten_ff[F];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= vld_ff[F];
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign out_valid = out_vld_ff;
   assign out_hsi = out_ff;

   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> out_ff.sat <= SAT_ONE)
      else $error("saturation above one");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> out_ff.hue < 16'd46080)
      else $error("hue not wrapped to 0..360");

endmodule

FILE: rtl/hsi_ratio.sv
// Gain/offset apply, sector fold, rotation CORDIC and divider for cos(h)/cos(60-h).
module hsi_ratio (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  hsi_pkg::hsi_type      in_hsi,
   input  logic [15:0]           gain,
   input  logic signed [8:0]     offset,
   output logic                  out_valid,
   output hsi_pkg::synth_in_type out_data
);
   import hsi_pkg::*;

   localparam int N = TRIG_STEPS;
   localparam int D = RATIO_DIV_STEPS;

   logic [31:0]        gprod_c;
   logic signed [17:0] off_ext_c, inten_ext_c;
   logic [13:0]        h_c;
   side_type           side_c;
   logic signed [24:0] z0_c;

   logic [N:0]         rot_vld_ff;
   logic signed [32:0] x_ff [0:N];
   logic signed [32:0] y_ff [0:N];
   logic signed [24:0] z_ff [0:N];
   side_type           rside_ff [0:N];
   logic signed [32:0] x_in [0:N-1];
   logic signed [32:0] y_in [0:N-1];
   logic signed [24:0] z_in [0:N-1];

   logic [31:0]        den_c;
   logic signed [32:0] ay33_c;
   logic [47:0]        nprod_c;

   logic [D:0]         div_vld_ff;
   logic [31:0]        rem_ff [0:D];
   logic [31:0]        den_ff [0:D];
   logic [D-1:0]       nlo_ff [0:D];
   logic [D-1:0]       q_ff [0:D];
   logic [D:0]         neg_ff;
   side_type           dside_ff [0:D];
   logic [31:0]        rem_in [0:D-1];
   logic [D-1:0]       q_in [0:D-1];

   logic signed [19:0] qs_c;
   synth_in_type       out_in, out_ff;
   logic               out_vld_ff;

   always_comb begin
      gprod_c = {16'b0, in_hsi.sat} * {16'b0, gain};
      off_ext_c = {offset[8], offset, 8'b0};
      inten_ext_c = $signed({2'b0, in_hsi.inten});
      side_c.sat_g = gprod_c[31:12];
      side_c.inten = inten_ext_c + off_ext_c;
      if (in_hsi.hue >= DEG240_Q7) begin
         side_c.sector = SECTOR_BLUE;
         h_c = 14'(in_hsi.hue - DEG240_Q7);
      end else if (in_hsi.hue >= DEG120_Q7) begin
         side_c.sector = SECTOR_GREEN;
         h_c = 14'(in_hsi.hue - DEG120_Q7);
      end else begin
         side_c.sector = SECTOR_RED;
         h_c = in_hsi.hue[13:0];
      end
      z0_c = 25'($signed({1'b0, h_c, 9'b0}) - DEG60_Q16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_vld_ff <= '0;
         div_vld_ff <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         rot_vld_ff <= {rot_vld_ff[N-1:0], in_valid};
         div_vld_ff <= {div_vld_ff[D-1:0], rot_vld_ff[N]};
         out_vld_ff <= div_vld_ff[D];
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]     <= ROT_X_INIT;
      y_ff[0]     <= '0;
      z_ff[0]     <= z0_c;
      rside_ff[0] <= side_c;
   end

   for (genvar i = 0; i < N; i++) begin : g_rot
      logic signed [24:0] ang;
      logic               pos;
      assign ang = $signed({3'b0, atan_q16(i)});
      assign pos = (z_ff[i] >= 0);
      assign x_in[i] = pos ? x_ff[i] - (y_ff[i] >>> i) : x_ff[i] + (y_ff[i] >>> i);
      assign y_in[i] = pos ? y_ff[i] + (x_ff[i] >>> i) : y_ff[i] - (x_ff[i] >>> i);
      assign z_in[i] = pos ? z_ff[i] - ang : z_ff[i] + ang;

      always_ff @(posedge clock) begin
         x_ff[i+1]     <= x_in[i];
         y_ff[i+1]     <= y_in[i];
         z_ff[i+1]     <= z_in[i];
         rside_ff[i+1] <= rside_ff[i];
      end
   end

   // divide |y|*sqrt3/2 by x as sign and magnitude, truncating toward zero
   always_comb begin
      den_c = (x_ff[N] > 0) ? x_ff[N][31:0] : 32'd1;
      ay33_c = (y_ff[N] < 0) ? -y_ff[N] : y_ff[N];
      nprod_c = {16'b0, ay33_c[31:0]} * HALF_SQRT3_Q16;
   end

   always_ff @(posedge clock) begin
      rem_ff[0]   <= 32'(nprod_c[47:D]);
      nlo_ff[0]   <= nprod_c[D-1:0];
      den_ff[0]   <= den_c;
      q_ff[0]     <= '0;
      neg_ff[0]   <= (y_ff[N] < 0);
      dside_ff[0] <= rside_ff[N];
   end

   for (genvar k = 0; k < D; k++) begin : g_div
      logic [32:0] trial, diff;
      logic        ge;
      assign trial = {rem_ff[k], nlo_ff[k][D-1-k]};
      assign ge = (trial >= {1'b0, den_ff[k]});
      assign diff = trial - {1'b0, den_ff[k]};
      assign rem_in[k] = ge ? diff[31:0] : trial[31:0];
      assign q_in[k] = {q_ff[k][D-2:0], ge};

      always_ff @(posedge clock) begin
         rem_ff[k+1]   <= rem_in[k];
         nlo_ff[k+1]   <= nlo_ff[k];
         den_ff[k+1]   <= den_ff[k];
         q_ff[k+1]     <= q_in[k];
         neg_ff[k+1]   <= neg_ff[k];
         dside_ff[k+1] <= dside_ff[k];
      end
   end

   always_comb begin
      qs_c = $signed(20'(q_ff[D]));
      out_in.side = dside_ff[D];
      out_in.ratio = neg_ff[D] ? 20'sd32768 + qs_c : 20'sd32768 - qs_c;
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign out_valid = out_vld_ff;
   assign out_data = out_ff;

   a_cos_positive: assert property (@(posedge clock) disable iff (reset)
      rot_vld_ff[N] |-> x_ff[N] > 0)
      else $error("rotation left the right half-plane");

endmodule

FILE: rtl/hsi_synth.sv
// HSI to RGB: sector products, third component, floor and clamp, sector permute.
module hsi_synth (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  hsi_pkg::synth_in_type  in_data,
   output logic                   out_strobe,
   output hsi_pkg::pixel_out_type out_pixel
);
   import hsi_pkg::*;

   function automatic logic [7:0] clamp_pixel(input logic signed [30:0] v);
      logic [7:0] p;
      if (v[30]) begin
         p = '0;
      end else if (v[29:16] != '0) begin
         p = '1;
      end else begin
         p = v[15:8];
      end
      return p;
   endfunction

   logic signed [20:0] satg_c, lf_c;
   logic signed [40:0] sr_in, sr_ff;
   logic signed [38:0] lowp_in, lowp_ff;
   logic signed [17:0] inten1_ff, inten2_ff;
   sector_type         sector1_ff, sector2_ff;

   logic signed [40:0] sr_sh_c;
   logic signed [26:0] factor_c;
   logic signed [44:0] prim_in, prim_ff;
   logic signed [38:0] low_sh_c;
   logic signed [23:0] low_in, low_ff;

   logic signed [44:0] prim_sh_c;
   logic signed [30:0] prim_v_c, low_v_c, inten_v_c, third_v_c;
   logic [7:0]         pp_c, pl_c, pt_c;
   pixel_out_type      pix_in, pix_ff;

   logic [2:0]         vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_comb begin
      satg_c = $signed({1'b0, in_data.side.sat_g});
      lf_c = 21'sd32768 - satg_c;
      sr_in = satg_c * in_data.ratio;
      lowp_in = in_data.side.inten * lf_c;
   end

   always_ff @(posedge clock) begin
      sr_ff      <= sr_in;
      lowp_ff    <= lowp_in;
      inten1_ff  <= in_data.side.inten;
      sector1_ff <= in_data.side.sector;
   end

   always_comb begin
      sr_sh_c = sr_ff >>> 15;
      factor_c = 27'sd65536 + $signed(sr_sh_c[26:0]);
      prim_in = inten1_ff * factor_c;
      low_sh_c = lowp_ff >>> 15;
      low_in = low_sh_c[23:0];
   end

   always_ff @(posedge clock) begin
      prim_ff    <= prim_in;
      low_ff     <= low_in;
      inten2_ff  <= inten1_ff;
      sector2_ff <= sector1_ff;
   end

   always_comb begin
      prim_sh_c = prim_ff >>> 16;
      prim_v_c = prim_sh_c[30:0];
      low_v_c = 31'(low_ff);
      inten_v_c = 31'(inten2_ff);
      third_v_c = 31'sd3 * inten_v_c - prim_v_c - low_v_c;
      pp_c = clamp_pixel(prim_v_c);
      pl_c = clamp_pixel(low_v_c);
      pt_c = clamp_pixel(third_v_c);
      case (sector2_ff)
         SECTOR_RED: begin
            pix_in.red_out = pp_c;
            pix_in.green_out = pt_c;
            pix_in.blue_out = pl_c;
         end
         SECTOR_GREEN: begin
            pix_in.red_out = pl_c;
            pix_in.green_out = pp_c;
            pix_in.blue_out = pt_c;
         end
         SECTOR_BLUE: begin
            pix_in.red_out = pt_c;
            pix_in.green_out = pl_c;
            pix_in.blue_out = pp_c;
         end
         default: begin
            pix_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
   end

   assign out_strobe = vld_ff[2];
   assign out_pixel = pix_ff;

endmodule
